// ===== sv/ibcc_pkg.sv =====
// Shared types and constants for the interval booking capacity check.
// Used by every module of the block except ibcc_ram; depends on nothing.
package ibcc_pkg;

   localparam int SlotW  = 10;
   localparam int ValueW = 32;
   localparam int OrderW = 20;
   localparam int TotalW = 48;

   localparam logic [OrderW-1:0] CountMax = {OrderW{1'b1}};
   localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_BOOK = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_REJECTED = 2'd1,
      ST_IGNORED  = 2'd2
   } status_type;

   // One classified item waiting for the back end. For a load, first holds the
   // slot and value the capacity; for a booking, value holds the amount and
   // last is already clipped to the table.
   typedef struct packed {
      logic              is_load;
      logic              no_walk;
      logic [SlotW-1:0]  first;
      logic [SlotW-1:0]  last;
      logic [ValueW-1:0] value;
      logic [OrderW-1:0] order;
   } queue_entry_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

// ===== sv/ibcc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ibcc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ibcc_queue.sv =====
// Two-entry queue of classified items between the front and back ends.
// Depends on ibcc_pkg.
module ibcc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ibcc_pkg::queue_entry_type push_entry,
   input  logic                     pop,
   output logic                     full,
   output logic                     valid,
   output ibcc_pkg::queue_entry_type head
);
   import ibcc_pkg::*;

   queue_entry_type entry_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

endmodule

// ===== sv/ibcc_front.sv =====
// Front end: accepts items, numbers bookings, clips ranges and drops loads
// outside the table before handing items to the queue. Depends on ibcc_pkg.
module ibcc_front #(
   parameter int unsigned SLOTS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_func,
   input  logic [ibcc_pkg::SlotW-1:0]            req_slot,
   input  logic [ibcc_pkg::ValueW-1:0]           req_capacity_value,
   input  logic [ibcc_pkg::ValueW-1:0]           req_amount,
   input  logic [ibcc_pkg::SlotW-1:0]            req_first_slot,
   input  logic [ibcc_pkg::SlotW-1:0]            req_last_slot,
   input  ibcc_pkg::back_status_type             back_status,
   input  logic                                  queue_full,
   output logic                                  push,
   output ibcc_pkg::queue_entry_type             push_entry
);
   import ibcc_pkg::*;

   localparam logic [31:0] SlotsC = 32'(SLOTS);

   logic [OrderW-1:0] count_ff, count_in;
   logic              accept;
   logic              is_load;
   logic [31:0]       slot_ext, first_ext, last_ext, last_clip;

   always_comb begin
      slot_ext  = 32'(req_slot);
      first_ext = 32'(req_first_slot);
      last_ext  = 32'(req_last_slot);
      last_clip = (last_ext >= SlotsC) ? (SlotsC - 32'd1) : last_ext;

      is_load = (req_func == FUNC_LOAD);
      busy    = back_status.clearing | queue_full;
      accept  = start & ~busy;

      count_in = count_ff;
      if (accept && !is_load && count_ff != CountMax) begin
         count_in = count_ff + OrderW'(1);
      end

      push_entry.is_load = is_load;
      push_entry.no_walk = (first_ext >= SlotsC) || (first_ext > last_clip);
      push_entry.first   = is_load ? req_slot : req_first_slot;
      // Clipping only lowers the value, so it still fits the slot field.
      push_entry.last    = last_clip[SlotW-1:0];
      push_entry.value   = is_load ? req_capacity_value : req_amount;
      push_entry.order   = count_in;

      push = accept && (!is_load || slot_ext < SlotsC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/ibcc_back.sv =====
// Back end: clears the reserved totals after reset, writes capacities and walks
// each booking's range one slot per cycle. Depends on ibcc_pkg.
module ibcc_back #(
   parameter int unsigned SLOTS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  queue_valid,
   input  ibcc_pkg::queue_entry_type             head,
   output logic                                  pop,
   output ibcc_pkg::back_status_type             back_status,
   output logic                                  tot_wr_en,
   output logic [$clog2(SLOTS)-1:0]              tot_wr_addr,
   output logic [ibcc_pkg::TotalW-1:0]           tot_wr_data,
   output logic                                  cap_wr_en,
   output logic [$clog2(SLOTS)-1:0]              cap_wr_addr,
   output logic [ibcc_pkg::ValueW-1:0]           cap_wr_data,
   output logic [$clog2(SLOTS)-1:0]              rd_addr,
   input  logic [ibcc_pkg::TotalW-1:0]           tot_rd_data,
   input  logic [ibcc_pkg::ValueW-1:0]           cap_rd_data,
   output logic                                  rsp_strobe,
   output logic [1:0]                            rsp_status,
   output logic [ibcc_pkg::OrderW-1:0]           rsp_order_number,
   output logic [ibcc_pkg::SlotW-1:0]            rsp_failing_slot
);
   import ibcc_pkg::*;

   localparam int AW = $clog2(SLOTS);
   localparam logic [AW-1:0] LastAddr = AW'(SLOTS - 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK
   } state_type;

   state_type         state_ff;
   logic [AW-1:0]     cur_ff;
   logic [AW-1:0]     last_ff;
   logic [ValueW-1:0] amount_ff;
   logic [OrderW-1:0] order_ff;
   logic              failed_ff;
   logic              found_ff;
   logic [SlotW-1:0]  fail_slot_ff;
   logic              strobe_ff;
   status_type        status_ff;
   logic [OrderW-1:0] rsp_order_ff;
   logic [SlotW-1:0]  rsp_slot_ff;

   logic [TotalW:0]   sum;
   logic [TotalW-1:0] total_new;
   logic              over;
   logic              is_end;

   always_comb begin
      sum       = {1'b0, tot_rd_data} + (TotalW+1)'(amount_ff);
      total_new = sum[TotalW] ? TotalMax : sum[TotalW-1:0];
      over      = total_new > TotalW'(cap_rd_data);
      is_end    = (cur_ff == last_ff);

      pop                  = (state_ff == S_IDLE) && queue_valid;
      back_status.clearing = (state_ff == S_CLEAR);

      tot_wr_en   = (state_ff == S_CLEAR) || (state_ff == S_WALK);
      tot_wr_addr = cur_ff;
      tot_wr_data = (state_ff == S_CLEAR) ? '0 : total_new;

      cap_wr_en   = pop && head.is_load;
      cap_wr_addr = AW'(head.first);
      cap_wr_data = head.value;

      // The next slot is read while the current one is written back.
      rd_addr = (state_ff == S_WALK) ? (cur_ff + AW'(1)) : AW'(head.first);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         cur_ff    <= '0;
         failed_ff <= 1'b0;
         found_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               cur_ff <= cur_ff + AW'(1);
               if (cur_ff == LastAddr) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (pop && !head.is_load) begin
                  if (failed_ff || head.no_walk) begin
                     strobe_ff    <= 1'b1;
                     status_ff    <= failed_ff ? ST_IGNORED : ST_ACCEPTED;
                     rsp_order_ff <= head.order;
                     rsp_slot_ff  <= '0;
                  end else begin
                     state_ff  <= S_WALK;
                     cur_ff    <= AW'(head.first);
                     last_ff   <= AW'(head.last);
                     amount_ff <= head.value;
                     order_ff  <= head.order;
                     found_ff  <= 1'b0;
                  end
               end
            end
            S_WALK: begin
               if (over && !found_ff) begin
                  found_ff     <= 1'b1;
                  fail_slot_ff <= SlotW'(cur_ff);
               end
               cur_ff <= cur_ff + AW'(1);
               if (is_end) begin
                  state_ff     <= S_IDLE;
                  strobe_ff    <= 1'b1;
                  rsp_order_ff <= order_ff;
                  if (found_ff || over) begin
                     status_ff   <= ST_REJECTED;
                     rsp_slot_ff <= found_ff ? fail_slot_ff : SlotW'(cur_ff);
                     failed_ff   <= 1'b1;
                  end else begin
                     status_ff   <= ST_ACCEPTED;
                     rsp_slot_ff <= '0;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_order_number = rsp_order_ff;
   assign rsp_failing_slot = rsp_slot_ff;

endmodule

// ===== sv/interval_booking_capacity_check_top.sv =====
// Top level of the interval booking capacity check: front end, item queue,
// back end and the two slot tables. Depends on ibcc_pkg and all ibcc_ modules.
//
// After reset the block clears its reserved totals, one slot per cycle, and holds
// busy high while it does so. Once running, busy is high only while the two-entry
// queue between front and back end is full. A load writes its capacity as it
// leaves the queue. A booking that is ignored, or whose range is empty, is answered
// without a walk. Any other booking leaves the queue and then walks its range with
// one read-modify-write of the totals table per slot, checked against the capacity
// table. Each booking yields one result on rsp_strobe for a single cycle; the
// receiver cannot stall, and loads yield none.
module interval_booking_capacity_check_top #(
   parameter int unsigned SLOTS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_func,
   input  logic [ibcc_pkg::SlotW-1:0]            req_slot,
   input  logic [ibcc_pkg::ValueW-1:0]           req_capacity_value,
   input  logic [ibcc_pkg::ValueW-1:0]           req_amount,
   input  logic [ibcc_pkg::SlotW-1:0]            req_first_slot,
   input  logic [ibcc_pkg::SlotW-1:0]            req_last_slot,
   output logic                                  rsp_strobe,
   output logic [1:0]                            rsp_status,
   output logic [ibcc_pkg::OrderW-1:0]           rsp_order_number,
   output logic [ibcc_pkg::SlotW-1:0]            rsp_failing_slot
);
   import ibcc_pkg::*;

   localparam int AW = $clog2(SLOTS);

   back_status_type   back_status;
   logic              queue_full;
   logic              queue_valid;
   logic              push;
   logic              pop;
   queue_entry_type   push_entry;
   queue_entry_type   head;
   logic              tot_wr_en;
   logic [AW-1:0]     tot_wr_addr;
   logic [TotalW-1:0] tot_wr_data;
   logic              cap_wr_en;
   logic [AW-1:0]     cap_wr_addr;
   logic [ValueW-1:0] cap_wr_data;
   logic [AW-1:0]     rd_addr;
   logic [TotalW-1:0] tot_rd_data;
   logic [ValueW-1:0] cap_rd_data;

   ibcc_front #(.SLOTS(SLOTS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_slot           (req_slot),
      .req_capacity_value (req_capacity_value),
      .req_amount         (req_amount),
      .req_first_slot     (req_first_slot),
      .req_last_slot      (req_last_slot),
      .back_status        (back_status),
      .queue_full         (queue_full),
      .push               (push),
      .push_entry         (push_entry)
   );

   ibcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .valid      (queue_valid),
      .head       (head)
   );

   ibcc_back #(.SLOTS(SLOTS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_valid      (queue_valid),
      .head             (head),
      .pop              (pop),
      .back_status      (back_status),
      .tot_wr_en        (tot_wr_en),
      .tot_wr_addr      (tot_wr_addr),
      .tot_wr_data      (tot_wr_data),
      .cap_wr_en        (cap_wr_en),
      .cap_wr_addr      (cap_wr_addr),
      .cap_wr_data      (cap_wr_data),
      .rd_addr          (rd_addr),
      .tot_rd_data      (tot_rd_data),
      .cap_rd_data      (cap_rd_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_order_number (rsp_order_number),
      .rsp_failing_slot (rsp_failing_slot)
   );

   ibcc_ram #(.WIDTH(TotalW), .DEPTH(SLOTS)) u_total_ram (
      .clock   (clock),
      .wr_en   (tot_wr_en),
      .wr_addr (tot_wr_addr),
      .wr_data (tot_wr_data),
      .rd_addr (rd_addr),
      .rd_data (tot_rd_data)
   );

   ibcc_ram #(.WIDTH(ValueW), .DEPTH(SLOTS)) u_capacity_ram (
      .clock   (clock),
      .wr_en   (cap_wr_en),
      .wr_addr (cap_wr_addr),
      .wr_data (cap_wr_data),
      .rd_addr (rd_addr),
      .rd_data (cap_rd_data)
   );

endmodule
